/* hw/rtl/sfa_pkg.sv */
// Shared types, constants and the set-1 scancode lookup for the keyboard FIFO.
`default_nettype none
package sfa_pkg;

	localparam int SFA_BUFFER_DEPTH = 256;

	localparam logic [7:0] SFA_RELEASE_BIT = 8'h80;

	localparam logic [6:0] SFA_ASCII_SPACE     = 7'h20;
	localparam logic [6:0] SFA_ASCII_BACKSPACE = 7'h08;
	localparam logic [6:0] SFA_ASCII_NEWLINE   = 7'h0A;
	localparam logic [6:0] SFA_ASCII_NONE      = 7'h00;

	localparam logic SFA_ACT_KEY  = 1'b0;
	localparam logic SFA_ACT_READ = 1'b1;

	typedef struct packed {
		logic       is_read;
		logic [6:0] ch;
	} sfa_cmd_t;

	// returns SFA_ASCII_NONE for release and unmapped codes
	function automatic logic [6:0] sfa_lookup(input logic [7:0] code);
		logic [6:0] ch;
		ch = SFA_ASCII_NONE;
		if ((code & SFA_RELEASE_BIT) == 8'h00) begin
			case (code)
				8'h1E: ch = 7'h61;
				8'h30: ch = 7'h62;
				8'h2E: ch = 7'h63;
				8'h20: ch = 7'h64;
				8'h12: ch = 7'h65;
				8'h21: ch = 7'h66;
				8'h22: ch = 7'h67;
				8'h23: ch = 7'h68;
				8'h17: ch = 7'h69;
				8'h24: ch = 7'h6A;
				8'h25: ch = 7'h6B;
				8'h26: ch = 7'h6C;
				8'h32: ch = 7'h6D;
				8'h31: ch = 7'h6E;
				8'h18: ch = 7'h6F;
				8'h19: ch = 7'h70;
				8'h10: ch = 7'h71;
				8'h13: ch = 7'h72;
				8'h1F: ch = 7'h73;
				8'h14: ch = 7'h74;
				8'h16: ch = 7'h75;
				8'h2F: ch = 7'h76;
				8'h11: ch = 7'h77;
				8'h2D: ch = 7'h78;
				8'h15: ch = 7'h79;
				8'h2C: ch = 7'h7A;
				8'h39: ch = SFA_ASCII_SPACE;
				8'h0E: ch = SFA_ASCII_BACKSPACE;
				8'h1C: ch = SFA_ASCII_NEWLINE;
				default: ch = SFA_ASCII_NONE;
			endcase
		end
		return ch;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/sfa_front.sv */
// Front end: accepts requests, decodes scancodes and drops release/unmapped codes.
`default_nettype none
module sfa_front
	import sfa_pkg::*;
(
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       action,
	input  wire logic [7:0] scancode,
	output logic            enq_valid,
	input  wire logic       enq_ready,
	output sfa_cmd_t        enq_cmd
);

	logic [6:0] ch;
	logic       keep;

	always_comb begin
		ch   = sfa_lookup(scancode);
		keep = (action == SFA_ACT_READ) || (ch != SFA_ASCII_NONE);
	end

	// dropped codes are consumed without touching the queue
	assign in_ready        = enq_ready;
	assign enq_valid       = in_valid && keep;
	assign enq_cmd.is_read = (action == SFA_ACT_READ);
	assign enq_cmd.ch      = ch;

endmodule
`default_nettype wire

/* hw/rtl/sfa_cmd_queue.sv */
// Two-entry command queue between the decode front end and the buffer back end.
`default_nettype none
module sfa_cmd_queue
	import sfa_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     enq_valid,
	output logic          enq_ready,
	input  wire sfa_cmd_t enq_cmd,
	output logic          deq_valid,
	input  wire logic     deq_ready,
	output sfa_cmd_t      deq_cmd
);

	sfa_cmd_t   entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_enq;
	logic       do_deq;

	assign enq_ready = (count_q != 2'd2);
	assign deq_valid = (count_q != 2'd0);
	assign deq_cmd   = entry_q[rd_ptr_q];
	assign do_enq    = enq_valid && enq_ready;
	assign do_deq    = deq_valid && deq_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_enq)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_deq)
				rd_ptr_q <= ~rd_ptr_q;
			case ({do_enq, do_deq})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_enq)
			entry_q[wr_ptr_q] <= enq_cmd;
	end

endmodule
`default_nettype wire

/* hw/rtl/sfa_back.sv */
// Back end: character ring buffer, head/tail pointers and the output register.
`default_nettype none
module sfa_back
	import sfa_pkg::*;
#(
	parameter int BUFFER_DEPTH = SFA_BUFFER_DEPTH
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     deq_valid,
	output logic          deq_ready,
	input  wire sfa_cmd_t deq_cmd,
	output logic          out_valid,
	input  wire logic     out_ready,
	output logic [6:0]    key_char
);

	localparam int PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);

	logic [6:0]       char_store_q [BUFFER_DEPTH];
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [6:0]       rd_data_q;
	logic             empty_q;
	logic             out_valid_q;
	logic             slot_free;
	logic             do_push;
	logic             do_pop;
	logic             fifo_empty;

	assign slot_free  = !out_valid_q || out_ready;
	assign fifo_empty = (head_q == tail_q);
	// pushes never wait on the output side; reads need a free output slot
	assign deq_ready  = !deq_cmd.is_read || slot_free;
	assign do_push    = deq_valid && !deq_cmd.is_read;
	assign do_pop     = deq_valid && deq_cmd.is_read && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_push)
				head_q <= (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
			if (do_pop && !fifo_empty)
				tail_q <= (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
			if (do_pop)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			char_store_q[head_q] <= deq_cmd.ch;
		if (do_pop) begin
			rd_data_q <= char_store_q[tail_q];
			empty_q   <= fifo_empty;
		end
	end

	assign out_valid = out_valid_q;
	assign key_char  = empty_q ? SFA_ASCII_NONE : rd_data_q;

endmodule
`default_nettype wire

/* hw/rtl/scancode_ascii_fifo_unit.sv */
// Top level: set-1 scancode to ASCII keyboard FIFO.
// A read request passes through the command queue, then the registered buffer read.
// Throughput: one request per cycle while the command queue has room; reads also
// wait for a free output register, so a held out_ready stalls them.
// Reset: arst_n clears pointers, command queue and output valid; buffer
// contents are not cleared and no clearing pass is run.
`default_nettype none
module scancode_ascii_fifo_unit
	import sfa_pkg::*;
#(
	parameter int BUFFER_DEPTH = SFA_BUFFER_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       action,
	input  wire logic [7:0] scancode,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [6:0]      key_char
);

	sfa_cmd_t enq_cmd;
	sfa_cmd_t deq_cmd;
	logic     enq_valid;
	logic     enq_ready;
	logic     deq_valid;
	logic     deq_ready;

	sfa_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.scancode  (scancode),
		.enq_valid (enq_valid),
		.enq_ready (enq_ready),
		.enq_cmd   (enq_cmd)
	);

	sfa_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.enq_valid (enq_valid),
		.enq_ready (enq_ready),
		.enq_cmd   (enq_cmd),
		.deq_valid (deq_valid),
		.deq_ready (deq_ready),
		.deq_cmd   (deq_cmd)
	);

	sfa_back #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.deq_valid (deq_valid),
		.deq_ready (deq_ready),
		.deq_cmd   (deq_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.key_char  (key_char)
	);

endmodule
`default_nettype wire

/* hw/rtl/sfa_checker.sv */
// Port-level checker for the keyboard FIFO, bound to the top level.
`default_nettype none
module sfa_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [6:0] key_char
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(key_char))
		else $error("result changed while stalled");

	// only decoded characters or the empty marker leave the block
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (key_char == 7'h00 || key_char == 7'h08 || key_char == 7'h0A ||
			key_char == 7'h20 || (key_char >= 7'h61 && key_char <= 7'h7A)))
		else $error("unexpected character on output");

	// no result right after reset is released
	a_reset_idle: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid out of reset");

	// in_valid, in_ready and out_valid are never unknown once out of reset
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_valid, in_ready, out_valid}))
		else $error("unknown handshake signal");

endmodule

bind scancode_ascii_fifo_unit sfa_checker u_sfa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.key_char  (key_char)
);
`default_nettype wire

/* bench/tb.sv */
// Testbench for the keyboard FIFO: directed table, full buffer, receiver hold, then random traffic.
`timescale 1ns / 100ps

module tb;
	import sfa_pkg::*;

	localparam int CLK_PERIOD     = 20;
	localparam int RESET_CYCLES   = 9;
	localparam int IDLE_PCT       = 27;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES   = 12;
	localparam int LIVE_TARGET    = 800;
	localparam int TIMEOUT_NS     = 4000000;
	localparam int MAKE_COUNT     = 29;

	// set-1 make codes and the ASCII they type, same order in both
	localparam logic [0:MAKE_COUNT-1][7:0] MAKE_CODES = {
		8'h1E, 8'h30, 8'h2E, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24,
		8'h25, 8'h26, 8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1F, 8'h14,
		8'h16, 8'h2F, 8'h11, 8'h2D, 8'h15, 8'h2C, 8'h39, 8'h0E, 8'h1C
	};
	localparam logic [0:MAKE_COUNT-1][6:0] MAKE_CHARS = {
		7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66, 7'h67, 7'h68, 7'h69, 7'h6A,
		7'h6B, 7'h6C, 7'h6D, 7'h6E, 7'h6F, 7'h70, 7'h71, 7'h72, 7'h73, 7'h74,
		7'h75, 7'h76, 7'h77, 7'h78, 7'h79, 7'h7A,
		SFA_ASCII_SPACE, SFA_ASCII_BACKSPACE, SFA_ASCII_NEWLINE
	};

	typedef struct packed {
		logic       act;
		logic [7:0] code;
		logic       typed;
		logic [6:0] ch;
	} kbd_row_t;

	localparam int DIRECTED_ROWS = 22;
	localparam kbd_row_t [0:DIRECTED_ROWS-1] DIRECTED = {
		{SFA_ACT_READ, 8'h00, 1'b1, SFA_ASCII_NONE},      // empty right after reset
		{SFA_ACT_READ, 8'hFF, 1'b1, SFA_ASCII_NONE},      // scancode ignored on read
		{SFA_ACT_KEY,  8'h00, 1'b0, SFA_ASCII_NONE},      // unmapped
		{SFA_ACT_KEY,  8'hFF, 1'b0, SFA_ASCII_NONE},      // release
		{SFA_ACT_KEY,  8'h80, 1'b0, SFA_ASCII_NONE},
		{SFA_ACT_KEY,  8'h7F, 1'b0, SFA_ASCII_NONE},
		{SFA_ACT_READ, 8'h55, 1'b1, SFA_ASCII_NONE},      // dropped codes left no char
		{SFA_ACT_KEY,  8'h1E, 1'b0, SFA_ASCII_NONE},
		{SFA_ACT_KEY,  8'h9E, 1'b0, SFA_ASCII_NONE},      // release of 'a'
		{SFA_ACT_READ, 8'hAA, 1'b1, 7'h61},
		{SFA_ACT_READ, 8'h00, 1'b1, SFA_ASCII_NONE},
		{SFA_ACT_KEY,  8'h2C, 1'b0, SFA_ASCII_NONE},
		{SFA_ACT_KEY,  8'h39, 1'b0, SFA_ASCII_NONE},
		{SFA_ACT_KEY,  8'h0E, 1'b0, SFA_ASCII_NONE},
		{SFA_ACT_KEY,  8'h1C, 1'b0, SFA_ASCII_NONE},
		{SFA_ACT_KEY,  8'h10, 1'b0, SFA_ASCII_NONE},
		{SFA_ACT_READ, 8'h00, 1'b1, 7'h7A},
		{SFA_ACT_READ, 8'h00, 1'b1, SFA_ASCII_SPACE},
		{SFA_ACT_READ, 8'h00, 1'b1, SFA_ASCII_BACKSPACE},
		{SFA_ACT_READ, 8'h00, 1'b1, SFA_ASCII_NEWLINE},
		{SFA_ACT_READ, 8'h00, 1'b0, SFA_ASCII_NONE},
		{SFA_ACT_READ, 8'h00, 1'b1, SFA_ASCII_NONE}
	};

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       action    = SFA_ACT_KEY;
	logic [7:0] scancode  = 8'h00;
	logic       out_ready = 1'b0;
	logic       in_ready;
	logic       out_valid;
	logic [6:0] key_char;

	// predicted keyboard buffer
	logic [6:0] ring_chars [SFA_BUFFER_DEPTH];
	int         head_pos = 0;
	int         tail_pos = 0;

	logic [6:0] pending_chars [$];
	int         mismatches  = 0;
	int         live_reqs   = 0;
	bit         steady_flow = 1'b0;
	bit         hold_req    = 1'b0;

	scancode_ascii_fifo_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.scancode  (scancode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.key_char  (key_char)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic [6:0] ascii_of_make(input logic [7:0] code);
		logic [6:0] ch;
		ch = SFA_ASCII_NONE;
		if (!code[7]) begin
			for (int k = 0; k < MAKE_COUNT; k++) begin
				if (MAKE_CODES[k] == code)
					ch = MAKE_CHARS[k];
			end
		end
		return ch;
	endfunction

	function automatic logic [7:0] any_make_code();
		return MAKE_CODES[$urandom_range(MAKE_COUNT - 1)];
	endfunction

	// release of a real key, or any byte at all
	function automatic logic [7:0] noise_code();
		if ($urandom_range(1))
			return any_make_code() | SFA_RELEASE_BIT;
		return 8'($urandom_range(255));
	endfunction

	task automatic predict_key_char(input logic act, input logic [7:0] code,
			output bit has_char, output logic [6:0] ch);
		logic [6:0] typed_in;
		has_char = 1'b0;
		ch = SFA_ASCII_NONE;
		if (act == SFA_ACT_KEY) begin
			typed_in = ascii_of_make(code);
			if (typed_in != SFA_ASCII_NONE) begin
				ring_chars[head_pos] = typed_in;
				head_pos = (head_pos + 1) % SFA_BUFFER_DEPTH;
			end
		end else begin
			has_char = 1'b1;
			if (tail_pos != head_pos) begin
				ch = ring_chars[tail_pos];
				tail_pos = (tail_pos + 1) % SFA_BUFFER_DEPTH;
			end
		end
	endtask

	task automatic put_request(input logic act, input logic [7:0] code,
			input logic typed, input logic [6:0] typed_ch);
		bit         has_char;
		logic [6:0] ch;
		while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		scancode <= code;
		do begin
			@(posedge clk);
		end while (!in_ready);
		if (act == SFA_ACT_READ || ascii_of_make(code) != SFA_ASCII_NONE)
			live_reqs++;
		predict_key_char(act, code, has_char, ch);
		if (has_char)
			pending_chars.push_back(typed ? typed_ch : ch);
	endtask

	task automatic put_key(input logic [7:0] code);
		put_request(SFA_ACT_KEY, code, 1'b0, SFA_ASCII_NONE);
	endtask

	task automatic put_read();
		put_request(SFA_ACT_READ, 8'($urandom_range(255)), 1'b0, SFA_ASCII_NONE);
	endtask

	// receiver: random back-pressure plus one long hold when asked
	initial begin : rx_side
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = RX_HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin : check_out
		logic [6:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_chars.size() == 0) begin
				$display("%0t: key_char expected none, actual %h", $time, key_char);
				mismatches++;
			end else begin
				want = pending_chars.pop_front();
				if (key_char !== want) begin
					$display("%0t: key_char expected %h, actual %h", $time, want, key_char);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#(TIMEOUT_NS);
		$display("[scancode_ascii_fifo_unit] ERROR");
		$finish;
	end

	initial begin : stimulus
		int n;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++)
			put_request(DIRECTED[i].act, DIRECTED[i].code, DIRECTED[i].typed, DIRECTED[i].ch);

		// full buffer: a whole lap of pushes makes the head catch the tail
		while (head_pos != tail_pos)
			put_read();
		repeat (SFA_BUFFER_DEPTH) begin
			if ($urandom_range(99) < 10)
				put_key(any_make_code() | SFA_RELEASE_BIT);
			put_key(any_make_code());
		end
		put_read();
		repeat (3) put_key(any_make_code());
		repeat (4) put_read();

		// long receiver hold while reads keep coming
		hold_req = 1'b1;
		repeat (8) put_key(any_make_code());
		repeat (40) put_read();

		while (live_reqs < LIVE_TARGET) begin
			steady_flow = (live_reqs >= 450 && live_reqs < 600);
			n = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
			repeat (n) begin
				if ($urandom_range(99) < 15)
					put_key(noise_code());
				else
					put_key(any_make_code());
			end
			n = $urandom_range(1, 24);
			repeat (n) put_read();
		end
		steady_flow = 1'b0;

		in_valid <= 1'b0;
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[scancode_ascii_fifo_unit] OK");
		else
			$display("[scancode_ascii_fifo_unit] ERROR");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/sfa_pkg.sv
hw/rtl/sfa_front.sv
hw/rtl/sfa_cmd_queue.sv
hw/rtl/sfa_back.sv
hw/rtl/scancode_ascii_fifo_unit.sv
hw/rtl/sfa_checker.sv
bench/tb.sv
